FILE: rtl/sps_pkg.sv
// types, codes and reset values shared by the station poll sequencer
package sps_pkg;

    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIMEOUTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 3'd4;

    // configuration reset values
    localparam logic [2:0] RST_MAX_TIMEOUTS = 3'd5;
    localparam logic [2:0] RST_MAX_ERRORS   = 3'd5;
    localparam logic [7:0] RST_ACK_CODE     = 8'h06;
    localparam logic [5:0] RST_REQ_TIMEOUT  = 6'd6;
    localparam logic [5:0] RST_ECHO_TIMEOUT = 6'd2;

    // event codes
    localparam logic [2:0] EV_START   = 3'd0;
    localparam logic [2:0] EV_DONE    = 3'd1;
    localparam logic [2:0] EV_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_CANCEL  = 3'd3;
    localparam logic [2:0] EV_LINKERR = 3'd4;
    localparam logic [2:0] EV_STOP    = 3'd5;

    // action codes
    localparam logic [3:0] A_NONE      = 4'd0;
    localparam logic [3:0] A_SEND_WAKE = 4'd1;
    localparam logic [3:0] A_READ_ECHO = 4'd2;
    localparam logic [3:0] A_SEND_ID   = 4'd3;
    localparam logic [3:0] A_READ_ACK  = 4'd4;
    localparam logic [3:0] A_READ_ID   = 4'd5;
    localparam logic [3:0] A_WAIT_TICK = 4'd6;
    localparam logic [3:0] A_SEND_MEAS = 4'd7;
    localparam logic [3:0] A_READ_MEAS = 4'd8;
    localparam logic [3:0] A_CLOSE     = 4'd9;

    // fault codes
    localparam logic [2:0] F_NONE     = 3'd0;
    localparam logic [2:0] F_TIMEOUTS = 3'd1;
    localparam logic [2:0] F_LINK     = 3'd2;
    localparam logic [2:0] F_ACK      = 3'd3;
    localparam logic [2:0] F_CRC      = 3'd4;
    localparam logic [2:0] F_UNKNOWN  = 3'd5;
    localparam logic [2:0] F_STORE    = 3'd6;

    // line garbage seen in place of an ack
    localparam logic [7:0] ACK_LF = 8'h0A;
    localparam logic [7:0] ACK_CR = 8'h0D;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef enum logic [12:0] {
        ST_STARTING = 13'b0000000000001,
        ST_WAKE_ST  = 13'b0000000000010,
        ST_ECHO_ST  = 13'b0000000000100,
        ST_REQ_ST   = 13'b0000000001000,
        ST_ACK_ST   = 13'b0000000010000,
        ST_DATA_ST  = 13'b0000000100000,
        ST_TICK     = 13'b0000001000000,
        ST_WAKE_MS  = 13'b0000010000000,
        ST_ECHO_MS  = 13'b0000100000000,
        ST_REQ_MS   = 13'b0001000000000,
        ST_ACK_MS   = 13'b0010000000000,
        ST_DATA_MS  = 13'b0100000000000,
        ST_STOPPED  = 13'b1000000000000
    } sps_state_t;

    typedef struct packed {
        logic [2:0] max_timeouts;
        logic [2:0] max_errors;
        logic [7:0] ack_code;
        logic [5:0] request_timeout_s;
        logic [5:0] echo_timeout_s;
    } sps_cfg_t;

    // tdata part of an event beat, ack_byte lowest
    typedef struct packed {
        logic       store_ok;
        logic       station_found;
        logic       data_valid;
        logic [7:0] ack_byte;
    } sps_evt_t;

    // result beat, action lowest
    typedef struct packed {
        logic [2:0] fault;
        logic [3:0] state_now;
        logic       flush_link;
        logic [5:0] timeout_secs;
        logic [3:0] action;
    } sps_res_t;

    typedef struct packed {
        sps_state_t state;
        logic [2:0] timeout_count;
        logic [2:0] error_count;
    } sps_ctx_t;

endpackage

FILE: rtl/sps_step.sv
// next-state and result logic for one event of the poll sequencer
module sps_step
(
    input  sps_pkg::sps_cfg_t cfg,
    input  sps_pkg::sps_ctx_t ctx,
    input  logic [2:0]        mode,
    input  sps_pkg::sps_evt_t evt,
    output sps_pkg::sps_ctx_t ctx_next,
    output sps_pkg::sps_res_t res
);

    sps_pkg::sps_state_t rs_state;
    logic [3:0]          rs_action;
    logic [2:0]          tc_inc;
    logic [2:0]          ec_inc;
    logic [3:0]          action;
    logic [5:0]          tmo;
    logic                flush;
    logic [2:0]          fault;
    logic [3:0]          code;

    // restart point of the current sequence
    always_comb
    begin
        case (ctx.state)
            sps_pkg::ST_WAKE_ST, sps_pkg::ST_ECHO_ST:
            begin
                rs_state  = sps_pkg::ST_WAKE_ST;
                rs_action = sps_pkg::A_SEND_WAKE;
            end
            sps_pkg::ST_REQ_ST, sps_pkg::ST_ACK_ST, sps_pkg::ST_DATA_ST:
            begin
                rs_state  = sps_pkg::ST_REQ_ST;
                rs_action = sps_pkg::A_SEND_ID;
            end
            sps_pkg::ST_WAKE_MS, sps_pkg::ST_ECHO_MS:
            begin
                rs_state  = sps_pkg::ST_WAKE_MS;
                rs_action = sps_pkg::A_SEND_WAKE;
            end
            default:
            begin
                rs_state  = sps_pkg::ST_REQ_MS;
                rs_action = sps_pkg::A_SEND_MEAS;
            end
        endcase
    end

    assign tc_inc = (ctx.timeout_count == sps_pkg::COUNT_MAX) ?
                    sps_pkg::COUNT_MAX : ctx.timeout_count + 3'd1;
    assign ec_inc = (ctx.error_count == sps_pkg::COUNT_MAX) ?
                    sps_pkg::COUNT_MAX : ctx.error_count + 3'd1;

    always_comb
    begin
        ctx_next = ctx;
        action   = sps_pkg::A_NONE;
        tmo      = 6'd0;
        flush    = 1'b0;
        fault    = sps_pkg::F_NONE;

        if (mode == sps_pkg::EV_STOP)
        begin
            ctx_next.state = sps_pkg::ST_STOPPED;
            action         = sps_pkg::A_CLOSE;
        end
        else if (mode > sps_pkg::EV_STOP)
        begin
            action = sps_pkg::A_NONE;
        end
        else if (mode == sps_pkg::EV_START || ctx.state == sps_pkg::ST_STARTING)
        begin
            ctx_next.timeout_count = 3'd0;
            ctx_next.error_count   = 3'd0;
            ctx_next.state         = sps_pkg::ST_WAKE_ST;
            action                 = sps_pkg::A_SEND_WAKE;
            tmo                    = cfg.request_timeout_s;
        end
        else if (ctx.state == sps_pkg::ST_STOPPED)
        begin
            action = sps_pkg::A_NONE;
        end
        else if (ctx.state == sps_pkg::ST_TICK)
        begin
            flush = 1'b1;
            if (mode == sps_pkg::EV_TIMEOUT)
            begin
                ctx_next.state = sps_pkg::ST_WAKE_MS;
                action         = sps_pkg::A_SEND_WAKE;
                tmo            = cfg.request_timeout_s;
            end
            else
            begin
                ctx_next.timeout_count = 3'd0;
                ctx_next.error_count   = 3'd0;
                action                 = sps_pkg::A_WAIT_TICK;
            end
        end
        else if (mode == sps_pkg::EV_TIMEOUT)
        begin
            ctx_next.timeout_count = tc_inc;
            if (tc_inc < cfg.max_timeouts)
            begin
                ctx_next.state = rs_state;
                action         = rs_action;
                tmo            = cfg.request_timeout_s;
                flush          = 1'b1;
            end
            else
            begin
                ctx_next.state = sps_pkg::ST_STOPPED;
                action         = sps_pkg::A_CLOSE;
                fault          = sps_pkg::F_TIMEOUTS;
            end
        end
        else if (mode == sps_pkg::EV_LINKERR)
        begin
            ctx_next.state = sps_pkg::ST_STOPPED;
            action         = sps_pkg::A_CLOSE;
            fault          = sps_pkg::F_LINK;
        end
        else if (mode == sps_pkg::EV_DONE)
        begin
            case (ctx.state)
                sps_pkg::ST_WAKE_ST:
                begin
                    ctx_next.state = sps_pkg::ST_ECHO_ST;
                    action         = sps_pkg::A_READ_ECHO;
                    tmo            = cfg.echo_timeout_s;
                end
                sps_pkg::ST_WAKE_MS:
                begin
                    ctx_next.state = sps_pkg::ST_ECHO_MS;
                    action         = sps_pkg::A_READ_ECHO;
                    tmo            = cfg.echo_timeout_s;
                end
                sps_pkg::ST_ECHO_ST:
                begin
                    ctx_next.state = sps_pkg::ST_REQ_ST;
                    action         = sps_pkg::A_SEND_ID;
                    tmo            = cfg.request_timeout_s;
                    flush          = 1'b1;
                end
                sps_pkg::ST_ECHO_MS:
                begin
                    ctx_next.state = sps_pkg::ST_REQ_MS;
                    action         = sps_pkg::A_SEND_MEAS;
                    tmo            = cfg.request_timeout_s;
                    flush          = 1'b1;
                end
                sps_pkg::ST_REQ_ST, sps_pkg::ST_REQ_MS:
                begin
                    ctx_next.state = (ctx.state == sps_pkg::ST_REQ_ST) ?
                                     sps_pkg::ST_ACK_ST : sps_pkg::ST_ACK_MS;
                    action         = sps_pkg::A_READ_ACK;
                    tmo            = cfg.request_timeout_s;
                end
                sps_pkg::ST_ACK_ST, sps_pkg::ST_ACK_MS:
                begin
                    tmo = cfg.request_timeout_s;
                    if (evt.ack_byte == sps_pkg::ACK_LF || evt.ack_byte == sps_pkg::ACK_CR)
                    begin
                        action = sps_pkg::A_READ_ACK;
                    end
                    else if (evt.ack_byte != cfg.ack_code)
                    begin
                        ctx_next.error_count = ec_inc;
                        if (ec_inc < cfg.max_errors)
                        begin
                            ctx_next.state = rs_state;
                            action         = rs_action;
                            flush          = 1'b1;
                        end
                        else
                        begin
                            ctx_next.state = sps_pkg::ST_STOPPED;
                            action         = sps_pkg::A_CLOSE;
                            tmo            = 6'd0;
                            fault          = sps_pkg::F_ACK;
                        end
                    end
                    else if (ctx.state == sps_pkg::ST_ACK_ST)
                    begin
                        ctx_next.state = sps_pkg::ST_DATA_ST;
                        action         = sps_pkg::A_READ_ID;
                    end
                    else
                    begin
                        ctx_next.state = sps_pkg::ST_DATA_MS;
                        action         = sps_pkg::A_READ_MEAS;
                    end
                end
                sps_pkg::ST_DATA_ST, sps_pkg::ST_DATA_MS:
                begin
                    if (!evt.data_valid)
                    begin
                        ctx_next.error_count = ec_inc;
                        if (ec_inc < cfg.max_errors)
                        begin
                            ctx_next.state = rs_state;
                            action         = rs_action;
                            tmo            = cfg.request_timeout_s;
                            flush          = 1'b1;
                        end
                        else
                        begin
                            ctx_next.state = sps_pkg::ST_STOPPED;
                            action         = sps_pkg::A_CLOSE;
                            fault          = sps_pkg::F_CRC;
                        end
                    end
                    else if ((ctx.state == sps_pkg::ST_DATA_ST) ? evt.station_found
                                                                : evt.store_ok)
                    begin
                        ctx_next.timeout_count = 3'd0;
                        ctx_next.error_count   = 3'd0;
                        ctx_next.state         = sps_pkg::ST_TICK;
                        action                 = sps_pkg::A_WAIT_TICK;
                        flush                  = 1'b1;
                    end
                    else
                    begin
                        ctx_next.state = sps_pkg::ST_STOPPED;
                        action         = sps_pkg::A_CLOSE;
                        fault          = (ctx.state == sps_pkg::ST_DATA_ST) ?
                                         sps_pkg::F_UNKNOWN : sps_pkg::F_STORE;
                    end
                end
                default:
                begin
                    action = sps_pkg::A_NONE;
                end
            endcase
        end
    end

    // numeric state code of the state after the event
    always_comb
    begin
        case (ctx_next.state)
            sps_pkg::ST_STARTING: code = 4'd0;
            sps_pkg::ST_WAKE_ST:  code = 4'd1;
            sps_pkg::ST_ECHO_ST:  code = 4'd2;
            sps_pkg::ST_REQ_ST:   code = 4'd3;
            sps_pkg::ST_ACK_ST:   code = 4'd4;
            sps_pkg::ST_DATA_ST:  code = 4'd5;
            sps_pkg::ST_TICK:     code = 4'd6;
            sps_pkg::ST_WAKE_MS:  code = 4'd7;
            sps_pkg::ST_ECHO_MS:  code = 4'd8;
            sps_pkg::ST_REQ_MS:   code = 4'd9;
            sps_pkg::ST_ACK_MS:   code = 4'd10;
            sps_pkg::ST_DATA_MS:  code = 4'd11;
            default:              code = 4'd12;
        endcase
    end

    assign res.action       = action;
    assign res.timeout_secs = tmo;
    assign res.flush_link   = flush;
    assign res.state_now    = code;
    assign res.fault        = fault;

endmodule

FILE: rtl/station_poll_sequencer_top.sv
// top level of the station poll sequencer: beat registers, state and configuration
//
// usage
//   events enter on the s_ stream: tuser carries the event kind, tdata the ack
//   byte and the crc, station-found and store-ok flags
//   each event yields exactly one result beat on the m_ stream: next link
//   action, its timeout, flush flag, protocol state after the event, fault code
//   configuration is written through cfg_we / cfg_index / cfg_data; the user must write
//   it only while idle, the block itself does not enforce this
// event flow
//   an event beat waits in an input register; once the result register can advance, one
//   pass of the step logic updates the protocol state and loads the result register;
//   one event per cycle sustained while m_tready stays high, set by the state update loop
// reset
//   rst_n clears both beat registers, puts the sequencer in its starting state
//   with zeroed counters and restores the configuration defaults
// stall
//   while m_tready is low the result holds; one more event may wait in the
//   input register, then s_tready drops until the result is taken
module station_poll_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // ack_byte, data_valid, station_found, store_ok, pad
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // action, timeout_secs, flush_link, state_now, fault, pad
    input  logic        cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data
);

    sps_pkg::sps_cfg_t cfg_reg;
    sps_pkg::sps_ctx_t ctx_reg;
    sps_pkg::sps_ctx_t ctx_next;
    logic              in_valid_reg;
    logic [2:0]        in_mode_reg;
    sps_pkg::sps_evt_t in_evt_reg;
    logic              out_valid_reg;
    sps_pkg::sps_res_t out_res_reg;
    sps_pkg::sps_res_t res;
    logic              adv;
    logic              s_fire;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_timeouts      <= sps_pkg::RST_MAX_TIMEOUTS;
            cfg_reg.max_errors        <= sps_pkg::RST_MAX_ERRORS;
            cfg_reg.ack_code          <= sps_pkg::RST_ACK_CODE;
            cfg_reg.request_timeout_s <= sps_pkg::RST_REQ_TIMEOUT;
            cfg_reg.echo_timeout_s    <= sps_pkg::RST_ECHO_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sps_pkg::CFG_MAX_TIMEOUTS: cfg_reg.max_timeouts      <= cfg_data[2:0];
                sps_pkg::CFG_MAX_ERRORS:   cfg_reg.max_errors        <= cfg_data[2:0];
                sps_pkg::CFG_ACK_CODE:     cfg_reg.ack_code          <= cfg_data[7:0];
                sps_pkg::CFG_REQ_TIMEOUT:  cfg_reg.request_timeout_s <= cfg_data[5:0];
                sps_pkg::CFG_ECHO_TIMEOUT: cfg_reg.echo_timeout_s    <= cfg_data[5:0];
                default:                   cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_mode_reg <= s_tuser;
            in_evt_reg  <= s_tdata[10:0];
        end
    end

    sps_step u_step
    (
        .cfg      (cfg_reg),
        .ctx      (ctx_reg),
        .mode     (in_mode_reg),
        .evt      (in_evt_reg),
        .ctx_next (ctx_next),
        .res      (res)
    );

    // protocol state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state         <= sps_pkg::ST_STARTING;
            ctx_reg.timeout_count <= 3'd0;
            ctx_reg.error_count   <= 3'd0;
            out_valid_reg         <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg};

    a_stop_closes: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_valid_reg && in_mode_reg == sps_pkg::EV_STOP
        |=> out_res_reg.action == sps_pkg::A_CLOSE && ctx_reg.state == sps_pkg::ST_STOPPED)
        else $error("stop event did not close the session");

    a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.state == sps_pkg::ST_TICK
        |-> ctx_reg.timeout_count == 3'd0 && ctx_reg.error_count == 3'd0)
        else $error("counters not clear while waiting for tick");

    a_close_stops: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_valid_reg && res.action == sps_pkg::A_CLOSE
        |=> ctx_reg.state == sps_pkg::ST_STOPPED && m_tvalid)
        else $error("close action without stopped state");

endmodule

FILE: tb/sv/tb_station_poll_sequencer_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the station poll sequencer: directed walk, then random events
module tb_station_poll_sequencer_top;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int LONG_HOLD       = 60;

    // protocol state as reported in state_now
    localparam logic [3:0] P_STARTING = 4'd0;
    localparam logic [3:0] P_WAKE_ST  = 4'd1;
    localparam logic [3:0] P_ECHO_ST  = 4'd2;
    localparam logic [3:0] P_REQ_ST   = 4'd3;
    localparam logic [3:0] P_ACK_ST   = 4'd4;
    localparam logic [3:0] P_DATA_ST  = 4'd5;
    localparam logic [3:0] P_TICK     = 4'd6;
    localparam logic [3:0] P_WAKE_MS  = 4'd7;
    localparam logic [3:0] P_ECHO_MS  = 4'd8;
    localparam logic [3:0] P_REQ_MS   = 4'd9;
    localparam logic [3:0] P_ACK_MS   = 4'd10;
    localparam logic [3:0] P_DATA_MS  = 4'd11;
    localparam logic [3:0] P_STOPPED  = 4'd12;

    typedef struct {
        logic [2:0]        mode;
        sps_pkg::sps_evt_t ev;
        bit                typed;
        sps_pkg::sps_res_t want;
    } walk_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;
    logic [2:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [23:0]                    m_tdata;
    logic                           cfg_we;
    logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sps_pkg::CFG_DATA_W-1:0] cfg_data;

    // sequencer model state and its copy of the registers
    logic [3:0] ps;
    logic [2:0] tmo_cnt;
    logic [2:0] err_cnt;
    logic [2:0] cfg_max_tmo;
    logic [2:0] cfg_max_err;
    logic [7:0] cfg_ack;
    logic [5:0] cfg_req_tmo;
    logic [5:0] cfg_echo_tmo;

    sps_pkg::sps_res_t expected_results[$];
    walk_row_t         walk[$];
    sps_pkg::sps_res_t mon_got;
    sps_pkg::sps_res_t mon_want;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int events_sent = 0;
    int results_seen = 0;
    int tick_waits = 0;
    int closes = 0;
    int cycle_count = 0;

    station_poll_sequencer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic sps_pkg::sps_res_t next_action(input logic [2:0] mode,
                                                      input sps_pkg::sps_evt_t ev);
        sps_pkg::sps_res_t r;
        logic [3:0]        rs;
        logic [3:0]        ract;
        logic [2:0]        bad;
        r = '0;
        bad = sps_pkg::F_NONE;
        // where a retry of the current step starts over
        if (ps <= P_ECHO_ST)
        begin
            rs = P_WAKE_ST;
            ract = sps_pkg::A_SEND_WAKE;
        end
        else if (ps <= P_DATA_ST)
        begin
            rs = P_REQ_ST;
            ract = sps_pkg::A_SEND_ID;
        end
        else if (ps <= P_ECHO_MS)
        begin
            rs = P_WAKE_MS;
            ract = sps_pkg::A_SEND_WAKE;
        end
        else
        begin
            rs = P_REQ_MS;
            ract = sps_pkg::A_SEND_MEAS;
        end
        if (mode == sps_pkg::EV_STOP)
        begin
            ps = P_STOPPED;
            r.action = sps_pkg::A_CLOSE;
        end
        else if (mode == sps_pkg::EV_START || (ps == P_STARTING && mode < sps_pkg::EV_STOP))
        begin
            tmo_cnt = '0;
            err_cnt = '0;
            ps = P_WAKE_ST;
            r.action = sps_pkg::A_SEND_WAKE;
            r.timeout_secs = cfg_req_tmo;
        end
        else if (mode > sps_pkg::EV_STOP || ps >= P_STOPPED)
        begin
            r.action = sps_pkg::A_NONE;
        end
        else if (ps == P_TICK)
        begin
            // a timeout here is the measure tick, not a failure
            if (mode == sps_pkg::EV_TIMEOUT)
            begin
                ps = P_WAKE_MS;
                r.action = sps_pkg::A_SEND_WAKE;
                r.timeout_secs = cfg_req_tmo;
                r.flush_link = 1'b1;
            end
            else
            begin
                tmo_cnt = '0;
                err_cnt = '0;
                r.action = sps_pkg::A_WAIT_TICK;
                r.flush_link = 1'b1;
            end
        end
        else if (mode == sps_pkg::EV_TIMEOUT)
        begin
            if (tmo_cnt != sps_pkg::COUNT_MAX)
                tmo_cnt = tmo_cnt + 3'd1;
            if (tmo_cnt < cfg_max_tmo)
            begin
                ps = rs;
                r.action = ract;
                r.timeout_secs = cfg_req_tmo;
                r.flush_link = 1'b1;
            end
            else
            begin
                ps = P_STOPPED;
                r.action = sps_pkg::A_CLOSE;
                r.fault = sps_pkg::F_TIMEOUTS;
            end
        end
        else if (mode == sps_pkg::EV_LINKERR)
        begin
            ps = P_STOPPED;
            r.action = sps_pkg::A_CLOSE;
            r.fault = sps_pkg::F_LINK;
        end
        else if (mode == sps_pkg::EV_DONE)
        begin
            case (ps)
                P_WAKE_ST, P_WAKE_MS:
                begin
                    ps = ps + 4'd1;
                    r.action = sps_pkg::A_READ_ECHO;
                    r.timeout_secs = cfg_echo_tmo;
                end
                P_ECHO_ST:
                begin
                    ps = P_REQ_ST;
                    r.action = sps_pkg::A_SEND_ID;
                    r.timeout_secs = cfg_req_tmo;
                    r.flush_link = 1'b1;
                end
                P_ECHO_MS:
                begin
                    ps = P_REQ_MS;
                    r.action = sps_pkg::A_SEND_MEAS;
                    r.timeout_secs = cfg_req_tmo;
                    r.flush_link = 1'b1;
                end
                P_REQ_ST, P_REQ_MS:
                begin
                    ps = ps + 4'd1;
                    r.action = sps_pkg::A_READ_ACK;
                    r.timeout_secs = cfg_req_tmo;
                end
                P_ACK_ST, P_ACK_MS:
                begin
                    // line garbage re-arms the ack read before the ack code is looked at
                    if (ev.ack_byte == sps_pkg::ACK_LF || ev.ack_byte == sps_pkg::ACK_CR)
                    begin
                        r.action = sps_pkg::A_READ_ACK;
                        r.timeout_secs = cfg_req_tmo;
                    end
                    else if (ev.ack_byte != cfg_ack)
                        bad = sps_pkg::F_ACK;
                    else
                    begin
                        ps = ps + 4'd1;
                        r.action = (ps == P_DATA_ST) ? sps_pkg::A_READ_ID : sps_pkg::A_READ_MEAS;
                        r.timeout_secs = cfg_req_tmo;
                    end
                end
                P_DATA_ST, P_DATA_MS:
                begin
                    if (!ev.data_valid)
                        bad = sps_pkg::F_CRC;
                    else if (ps == P_DATA_ST ? ev.station_found : ev.store_ok)
                    begin
                        tmo_cnt = '0;
                        err_cnt = '0;
                        ps = P_TICK;
                        r.action = sps_pkg::A_WAIT_TICK;
                        r.flush_link = 1'b1;
                    end
                    else
                    begin
                        r.fault = (ps == P_DATA_ST) ? sps_pkg::F_UNKNOWN : sps_pkg::F_STORE;
                        ps = P_STOPPED;
                        r.action = sps_pkg::A_CLOSE;
                    end
                end
                default: ;
            endcase
            if (bad != sps_pkg::F_NONE)
            begin
                if (err_cnt != sps_pkg::COUNT_MAX)
                    err_cnt = err_cnt + 3'd1;
                if (err_cnt < cfg_max_err)
                begin
                    ps = rs;
                    r.action = ract;
                    r.timeout_secs = cfg_req_tmo;
                    r.flush_link = 1'b1;
                end
                else
                begin
                    ps = P_STOPPED;
                    r.action = sps_pkg::A_CLOSE;
                    r.fault = bad;
                end
            end
        end
        r.state_now = ps;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] mode, input logic [7:0] ack, input logic [2:0] flags,
                           input bit typed = 1'b0, input logic [3:0] act = sps_pkg::A_NONE,
                           input logic [5:0] tmo = 6'd0, input logic flush = 1'b0,
                           input logic [3:0] st = P_STARTING,
                           input logic [2:0] flt = sps_pkg::F_NONE);
        walk_row_t row;
        row.mode = mode;
        row.ev = sps_pkg::sps_evt_t'({flags, ack});
        row.typed = typed;
        row.want = sps_pkg::sps_res_t'({flt, st, flush, tmo, act});
        walk.push_back(row);
    endtask

    task automatic send_event(input logic [2:0] mode, input sps_pkg::sps_evt_t ev,
                              input bit typed, input sps_pkg::sps_res_t want);
        sps_pkg::sps_res_t pred;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {5'b0, ev};
        do
            @(posedge clk);
        while (!s_tready);
        pred = next_action(mode, ev);
        expected_results.push_back(typed ? want : pred);
        events_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sps_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sps_pkg::CFG_MAX_TIMEOUTS: cfg_max_tmo = val[2:0];
            sps_pkg::CFG_MAX_ERRORS:   cfg_max_err = val[2:0];
            sps_pkg::CFG_ACK_CODE:     cfg_ack = val;
            sps_pkg::CFG_REQ_TIMEOUT:  cfg_req_tmo = val[5:0];
            sps_pkg::CFG_ECHO_TIMEOUT: cfg_echo_tmo = val[5:0];
            default: ;
        endcase
    endtask

    // mostly the event that moves the session on, with random content and some noise
    task automatic gen_event(output logic [2:0] mode, output sps_pkg::sps_evt_t ev);
        int roll;
        int pick;
        roll = $urandom_range(99);
        pick = $urandom_range(9);
        ev.ack_byte = 8'($urandom_range(255));
        ev.data_valid = 1'($urandom_range(1));
        ev.station_found = 1'($urandom_range(1));
        ev.store_ok = 1'($urandom_range(1));
        mode = sps_pkg::EV_DONE;
        if (roll < 12)
            mode = 3'($urandom_range(7));
        else if (roll < 20)
            mode = sps_pkg::EV_TIMEOUT;
        else if (roll < 23)
            mode = sps_pkg::EV_CANCEL;
        else if (roll < 25)
            mode = sps_pkg::EV_LINKERR;
        else if (roll < 26)
            mode = sps_pkg::EV_STOP;
        else
        begin
            case (ps)
                P_STARTING, P_STOPPED:
                    mode = sps_pkg::EV_START;
                P_TICK:
                    mode = (pick < 2) ? sps_pkg::EV_DONE : sps_pkg::EV_TIMEOUT;
                P_ACK_ST, P_ACK_MS:
                begin
                    if (pick < 7)
                        ev.ack_byte = cfg_ack;
                    else if (pick == 7)
                        ev.ack_byte = ev.data_valid ? sps_pkg::ACK_LF : sps_pkg::ACK_CR;
                end
                P_DATA_ST, P_DATA_MS:
                begin
                    ev.data_valid = (pick != 0);
                    ev.station_found = ($urandom_range(9) != 0);
                    ev.store_ok = ($urandom_range(9) != 0);
                end
                default: ;
            endcase
        end
    endtask

    task automatic run_phase(input int n, input int tx, input int rx);
        logic [2:0]        mode;
        sps_pkg::sps_evt_t ev;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        repeat (n)
        begin
            gen_event(mode, ev);
            send_event(mode, ev, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got = sps_pkg::sps_res_t'(m_tdata[17:0]);
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat mismatch, expected none actual %h", $time, mon_got);
                mismatches++;
            end
            else
            begin
                mon_want = expected_results.pop_front();
                check_field("action", mon_want.action, mon_got.action);
                check_field("timeout_secs", mon_want.timeout_secs, mon_got.timeout_secs);
                check_field("flush_link", mon_want.flush_link, mon_got.flush_link);
                check_field("state_now", mon_want.state_now, mon_got.state_now);
                check_field("fault", mon_want.fault, mon_got.fault);
                results_seen++;
                if (mon_want.action == sps_pkg::A_CLOSE)
                    closes++;
                if (mon_want.action == sps_pkg::A_WAIT_TICK)
                    tick_waits++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = sps_pkg::EV_START;
        cfg_we = 1'b0;
        cfg_index = sps_pkg::CFG_MAX_TIMEOUTS;
        cfg_data = '0;
        ps = P_STARTING;
        tmo_cnt = '0;
        err_cnt = '0;
        cfg_max_tmo = sps_pkg::RST_MAX_TIMEOUTS;
        cfg_max_err = sps_pkg::RST_MAX_ERRORS;
        cfg_ack = sps_pkg::RST_ACK_CODE;
        cfg_req_tmo = sps_pkg::RST_REQ_TIMEOUT;
        cfg_echo_tmo = sps_pkg::RST_ECHO_TIMEOUT;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk with default registers; flags are {store_ok, station_found, data_valid}
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000, 1'b1, sps_pkg::A_SEND_WAKE, 6'd6, 1'b0,
                P_WAKE_ST, sps_pkg::F_NONE);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, sps_pkg::ACK_LF, 3'b000);
        add_row(sps_pkg::EV_DONE, sps_pkg::ACK_CR, 3'b111);
        add_row(sps_pkg::EV_DONE, 8'hFF, 3'b111);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, sps_pkg::RST_ACK_CODE, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b011, 1'b1, sps_pkg::A_WAIT_TICK, 6'd0, 1'b1,
                P_TICK, sps_pkg::F_NONE);
        add_row(sps_pkg::EV_CANCEL, 8'h00, 3'b000);
        add_row(sps_pkg::EV_TIMEOUT, 8'h00, 3'b000);
        add_row(sps_pkg::EV_CANCEL, 8'hFF, 3'b111);
        add_row(sps_pkg::EV_TIMEOUT, 8'h00, 3'b000);
        add_row(3'd7, 8'hFF, 3'b111);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b000);
        add_row(sps_pkg::EV_DONE, sps_pkg::RST_ACK_CODE, 3'b000);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b110);
        add_row(3'd6, 8'h00, 3'b000);
        add_row(sps_pkg::EV_LINKERR, 8'h00, 3'b000, 1'b1, sps_pkg::A_CLOSE, 6'd0, 1'b0,
                P_STOPPED, sps_pkg::F_LINK);
        add_row(sps_pkg::EV_DONE, 8'h00, 3'b001, 1'b1, sps_pkg::A_NONE, 6'd0, 1'b0,
                P_STOPPED, sps_pkg::F_NONE);
        add_row(sps_pkg::EV_START, 8'h00, 3'b000, 1'b1, sps_pkg::A_SEND_WAKE, 6'd6, 1'b0,
                P_WAKE_ST, sps_pkg::F_NONE);
        add_row(sps_pkg::EV_STOP, 8'h00, 3'b000, 1'b1, sps_pkg::A_CLOSE, 6'd0, 1'b0,
                P_STOPPED, sps_pkg::F_NONE);
        add_row(sps_pkg::EV_CANCEL, 8'h00, 3'b000, 1'b1, sps_pkg::A_NONE, 6'd0, 1'b0,
                P_STOPPED, sps_pkg::F_NONE);

        tx_idle_pct = 13;
        rx_idle_pct = 73;
        foreach (walk[i])
            send_event(walk[i].mode, walk[i].ev, walk[i].typed, walk[i].want);
        drain();

        // lowest limits: any timeout or bad beat aborts
        write_reg(sps_pkg::CFG_MAX_TIMEOUTS, 8'd1);
        write_reg(sps_pkg::CFG_MAX_ERRORS, 8'd1);
        write_reg(sps_pkg::CFG_ACK_CODE, 8'h00);
        write_reg(sps_pkg::CFG_REQ_TIMEOUT, 8'd1);
        write_reg(sps_pkg::CFG_ECHO_TIMEOUT, 8'd1);
        run_phase(ITEMS_PER_PHASE, 13, 73);
        drain();

        write_reg(sps_pkg::CFG_MAX_TIMEOUTS, 8'd7);
        write_reg(sps_pkg::CFG_MAX_ERRORS, 8'd7);
        write_reg(sps_pkg::CFG_ACK_CODE, 8'hFF);
        write_reg(sps_pkg::CFG_REQ_TIMEOUT, 8'd63);
        write_reg(sps_pkg::CFG_ECHO_TIMEOUT, 8'd63);
        run_phase(ITEMS_PER_PHASE, 73, 13);
        drain();

        write_reg(sps_pkg::CFG_MAX_TIMEOUTS, 8'($urandom_range(6, 2)));
        write_reg(sps_pkg::CFG_MAX_ERRORS, 8'($urandom_range(6, 2)));
        write_reg(sps_pkg::CFG_ACK_CODE, 8'($urandom_range(255)));
        write_reg(sps_pkg::CFG_REQ_TIMEOUT, 8'($urandom_range(62, 2)));
        write_reg(sps_pkg::CFG_ECHO_TIMEOUT, 8'($urandom_range(62, 2)));
        hold_requests++;
        run_phase(ITEMS_PER_PHASE, 0, 0);
        drain();
        repeat (8) @(posedge clk);

        $display("%0d events under default, lowest, highest and random limits, %0d results checked",
                 events_sent, results_seen);
        $display("%0d tick waits entered, %0d sessions closed, %0d mismatches",
                 tick_waits, closes, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
